// File: rtl/dssg_pkg.sv
package dssg_pkg;

  localparam int VALUE_W    = 63;
  localparam int DIGIT_W    = 4;
  localparam int POS_W      = 5;
  localparam int GLYPH_W    = 35;
  localparam int MAX_DIGITS = 19;
  localparam int BCD_W      = MAX_DIGITS * DIGIT_W;
  localparam int BITCNT_W   = $clog2(VALUE_W);
  localparam int DEF_DIGIT_SLOTS = 20;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_EMIT
  } dssg_state_t;

  // Commands from the sequencer to the converter
  typedef struct packed {
    logic load;    // take a new binary value, clear the BCD digits
    logic conv;    // one shift-and-add-3 step
    logic dshift;  // drop the top digit, next one moves up
  } dssg_ctl_t;

  // segment bits: 0 top, 1 middle, 2 bottom, 3 upper-left, 4 lower-left,
  // 5 upper-right, 6 lower-right
  function automatic logic [6:0] seg_of(logic [DIGIT_W-1:0] d);
    logic [6:0] s;
    case (d)
      4'd0:    s = 7'h7D;
      4'd1:    s = 7'h60;
      4'd2:    s = 7'h37;
      4'd3:    s = 7'h67;
      4'd4:    s = 7'h6A;
      4'd5:    s = 7'h4F;
      4'd6:    s = 7'h5F;
      4'd7:    s = 7'h61;
      4'd8:    s = 7'h7F;
      4'd9:    s = 7'h6F;
      default: s = 7'h00;
    endcase
    return s;
  endfunction

  // 7 rows x 5 columns, bit row*5+col
  function automatic logic [GLYPH_W-1:0] glyph_of(logic [DIGIT_W-1:0] d);
    logic [6:0]         s;
    logic [GLYPH_W-1:0] g;
    s = seg_of(d);
    g = '0;
    if (s[0]) g[4:0]   = 5'h1F;
    if (s[1]) g[19:15] = 5'h1F;
    if (s[2]) g[34:30] = 5'h1F;
    for (int r = 0; r < 4; r++) begin
      if (s[3]) g[r*5]     = 1'b1;
      if (s[5]) g[r*5 + 4] = 1'b1;
    end
    for (int r = 4; r < 7; r++) begin
      if (s[4]) g[r*5]     = 1'b1;
      if (s[6]) g[r*5 + 4] = 1'b1;
    end
    return g;
  endfunction

endpackage

// File: rtl/dssg_dabble.sv
module dssg_dabble (
  input  logic                         clk,
  input  dssg_pkg::dssg_ctl_t          ctl,
  input  logic [dssg_pkg::VALUE_W-1:0] value,
  output logic [dssg_pkg::DIGIT_W-1:0] top_digit
);

  logic [dssg_pkg::VALUE_W-1:0] bin_r, bin_nxt;
  logic [dssg_pkg::BCD_W-1:0]   bcd_r, bcd_nxt;
  logic [dssg_pkg::BCD_W-1:0]   adj;

  // add 3 to every digit of 5 or more before the shift
  always_comb begin
    for (int i = 0; i < dssg_pkg::MAX_DIGITS; i++) begin
      if (bcd_r[i*dssg_pkg::DIGIT_W +: dssg_pkg::DIGIT_W] >= 4'd5)
        adj[i*dssg_pkg::DIGIT_W +: dssg_pkg::DIGIT_W] =
          bcd_r[i*dssg_pkg::DIGIT_W +: dssg_pkg::DIGIT_W] + 4'd3;
      else
        adj[i*dssg_pkg::DIGIT_W +: dssg_pkg::DIGIT_W] =
          bcd_r[i*dssg_pkg::DIGIT_W +: dssg_pkg::DIGIT_W];
    end
  end

  always_comb begin
    bin_nxt = bin_r;
    bcd_nxt = bcd_r;
    if (ctl.load) begin
      bin_nxt = value;
      bcd_nxt = '0;
    end else if (ctl.conv) begin
      bcd_nxt = {adj[dssg_pkg::BCD_W-2:0], bin_r[dssg_pkg::VALUE_W-1]};
      bin_nxt = {bin_r[dssg_pkg::VALUE_W-2:0], 1'b0};
    end else if (ctl.dshift) begin
      bcd_nxt = {bcd_r[dssg_pkg::BCD_W-dssg_pkg::DIGIT_W-1:0], {dssg_pkg::DIGIT_W{1'b0}}};
    end
  end

  always_ff @(posedge clk) begin
    bin_r <= bin_nxt;
    bcd_r <= bcd_nxt;
  end

  assign top_digit = bcd_r[dssg_pkg::BCD_W-1 -: dssg_pkg::DIGIT_W];

endmodule

// File: rtl/decimal_seven_segment_glyphs_core.sv
// Renders a 63-bit unsigned value as decimal seven-segment glyphs, one output
// item per digit, most significant first, without leading zeros (zero gives a
// single 0); out_last marks the least significant digit. If the number has
// more digits than DIGIT_SLOTS (capped at 19), only the low DIGIT_SLOTS digits
// come out. Each item is first converted in a bit-serial binary-to-BCD
// register by shift-and-add-3 steps over every input bit; then the BCD
// register shifts one digit per cycle, skipping leading zeros and emitting the
// rest through a one-entry output register, where a digit to be emitted waits
// while that register holds an unaccepted item. A new value is taken only when
// the last digit of the current one has been emitted: in_ready is high only
// between items.
module decimal_seven_segment_glyphs_core #(
  parameter int DIGIT_SLOTS = dssg_pkg::DEF_DIGIT_SLOTS
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [dssg_pkg::VALUE_W-1:0] in_value,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [dssg_pkg::DIGIT_W-1:0] out_digit,
  output logic [dssg_pkg::POS_W-1:0]   out_position,
  output logic [dssg_pkg::GLYPH_W-1:0] out_glyph,
  output logic                         out_last
);

  localparam int SLOTS = (DIGIT_SLOTS > dssg_pkg::MAX_DIGITS) ? dssg_pkg::MAX_DIGITS :
                         (DIGIT_SLOTS < 1) ? 1 : DIGIT_SLOTS;
  localparam logic [dssg_pkg::POS_W-1:0]    SLOTS_P  = dssg_pkg::POS_W'(SLOTS);
  localparam logic [dssg_pkg::POS_W-1:0]    TOP_IDX  = dssg_pkg::POS_W'(dssg_pkg::MAX_DIGITS - 1);
  localparam logic [dssg_pkg::BITCNT_W-1:0] LAST_BIT =
    dssg_pkg::BITCNT_W'(dssg_pkg::VALUE_W - 1);

  dssg_pkg::dssg_state_t state_r, state_nxt;
  dssg_pkg::dssg_ctl_t   ctl;

  logic [dssg_pkg::BITCNT_W-1:0] bit_cnt_r, bit_cnt_nxt;
  logic [dssg_pkg::POS_W-1:0]    cur_r, cur_nxt;
  logic [dssg_pkg::POS_W-1:0]    pos_r, pos_nxt;
  logic                          started_r, started_nxt;
  logic [dssg_pkg::DIGIT_W-1:0]  top_digit;

  logic                          out_valid_r, out_valid_nxt;
  logic [dssg_pkg::DIGIT_W-1:0]  out_digit_r;
  logic [dssg_pkg::POS_W-1:0]    out_pos_r;
  logic [dssg_pkg::GLYPH_W-1:0]  out_glyph_r;
  logic                          out_last_r;

  logic in_fire, slot_free, skip, emit;

  assign in_fire   = in_valid && in_ready;
  assign slot_free = !out_valid_r || out_ready;
  // digit above the slot window, or a leading zero that is not the units digit
  assign skip = (cur_r >= SLOTS_P) ||
                (!started_r && top_digit == '0 && cur_r != '0);
  assign emit = (state_r == dssg_pkg::ST_EMIT) && !skip && slot_free;

  dssg_dabble u_dabble (
    .clk       (clk),
    .ctl       (ctl),
    .value     (in_value),
    .top_digit (top_digit)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      dssg_pkg::ST_IDLE: if (in_fire) state_nxt = dssg_pkg::ST_CONV;
      dssg_pkg::ST_CONV: if (bit_cnt_r == LAST_BIT) state_nxt = dssg_pkg::ST_EMIT;
      dssg_pkg::ST_EMIT: if (emit && cur_r == '0) state_nxt = dssg_pkg::ST_IDLE;
      default:           state_nxt = dssg_pkg::ST_IDLE;
    endcase
  end

  // outputs and counters
  always_comb begin
    ctl         = '0;
    in_ready    = 1'b0;
    bit_cnt_nxt = bit_cnt_r;
    cur_nxt     = cur_r;
    pos_nxt     = pos_r;
    started_nxt = started_r;
    case (state_r)
      dssg_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_fire) begin
          ctl.load    = 1'b1;
          bit_cnt_nxt = '0;
          cur_nxt     = TOP_IDX;
          pos_nxt     = '0;
          started_nxt = 1'b0;
        end
      end
      dssg_pkg::ST_CONV: begin
        ctl.conv    = 1'b1;
        bit_cnt_nxt = bit_cnt_r + 1'b1;
      end
      dssg_pkg::ST_EMIT: begin
        if (skip || emit) begin
          ctl.dshift = 1'b1;
          if (cur_r != '0) cur_nxt = cur_r - 1'b1;
          // a nonzero digit above the window still ends the leading zeros
          if (top_digit != '0) started_nxt = 1'b1;
        end
        if (emit) begin
          pos_nxt     = pos_r + 1'b1;
          started_nxt = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (emit)
      out_valid_nxt = 1'b1;
    else if (out_ready)
      out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= dssg_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
      bit_cnt_r   <= '0;
      cur_r       <= '0;
      pos_r       <= '0;
      started_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      bit_cnt_r   <= bit_cnt_nxt;
      cur_r       <= cur_nxt;
      pos_r       <= pos_nxt;
      started_r   <= started_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_digit_r <= top_digit;
      out_pos_r   <= pos_r;
      out_glyph_r <= dssg_pkg::glyph_of(top_digit);
      out_last_r  <= (cur_r == '0);
    end
  end

  assign out_valid    = out_valid_r;
  assign out_digit    = out_digit_r;
  assign out_position = out_pos_r;
  assign out_glyph    = out_glyph_r;
  assign out_last     = out_last_r;

`ifndef SYNTH
  a_accept_starts_conv: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r == dssg_pkg::ST_CONV) && !in_ready)
    else $error("item accepted but conversion did not start");

  a_digit_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_digit <= 4'd9) && (out_position < SLOTS_P))
    else $error("output digit or position out of range");

  a_emit_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |-> !emit)
    else $error("new digit overwrote an unaccepted item");
`endif

endmodule
